/* sv/sbme_pkg.sv */
// Shared types and constants for the sprite bounce motion engine.
package sbme_pkg;

  localparam int unsigned POS_W    = 15;
  localparam int unsigned VEL_W    = 8;
  localparam int unsigned FLAG_W   = 3;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned SCREEN_W = 9;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 15;

  localparam logic [POS_W-1:0] RIGHT_LIMIT_RESET  = 15'((320 - 16) * 64);
  localparam logic [POS_W-1:0] BOTTOM_LIMIT_RESET = 15'((200 - 16) * 64);

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK     = 2'd0,
    KIND_MOTION   = 2'd1,
    KIND_POSITION = 2'd2,
    KIND_UNUSED   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RIGHT_LIMIT  = 2'd0,
    REG_BOTTOM_LIMIT = 2'd1,
    REG_SPARE2       = 2'd2,
    REG_SPARE3       = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
  } pos_entry_t;

  typedef struct packed {
    logic [VEL_W-1:0]  vx;
    logic [VEL_W-1:0]  vy;
    logic [FLAG_W-1:0] flags;
  } mot_entry_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  index;
    logic [SCREEN_W-1:0] screen_x;
    logic [SCREEN_W-1:0] screen_y;
    logic [FLAG_W-1:0]   flags;
    logic                last;
  } result_t;

  // Negate a 2.6 velocity, saturating the most negative code.
  function automatic logic [VEL_W-1:0] neg_sat(input logic [VEL_W-1:0] v);
    logic [VEL_W-1:0] r;
    if (v == {1'b1, {(VEL_W-1){1'b0}}}) begin
      r = {1'b0, {(VEL_W-1){1'b1}}};
    end else begin
      r = VEL_W'(~v + 1'b1);
    end
    return r;
  endfunction

endpackage

/* sv/sbme_if.sv */
// Channel interfaces: command requests, result requests and config writes.
interface sbme_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [sbme_pkg::KIND_W-1:0]      kind;
  logic [sbme_pkg::INDEX_W-1:0]     sprite_index;
  logic [sbme_pkg::POS_W-1:0]       new_pos_x;
  logic [sbme_pkg::POS_W-1:0]       new_pos_y;
  logic signed [sbme_pkg::VEL_W-1:0] new_vel_x;
  logic signed [sbme_pkg::VEL_W-1:0] new_vel_y;
  logic [sbme_pkg::FLAG_W-1:0]      new_flags;

  modport source (output valid, kind, sprite_index, new_pos_x, new_pos_y,
                  new_vel_x, new_vel_y, new_flags, input ready);
  modport sink (input valid, kind, sprite_index, new_pos_x, new_pos_y,
                new_vel_x, new_vel_y, new_flags, output ready);
endinterface

interface sbme_res_if;
  logic                           valid;
  logic                           ready;
  logic [sbme_pkg::INDEX_W-1:0]   out_index;
  logic [sbme_pkg::SCREEN_W-1:0]  screen_x;
  logic [sbme_pkg::SCREEN_W-1:0]  screen_y;
  logic [sbme_pkg::FLAG_W-1:0]    out_flags;
  logic                           last;

  modport source (output valid, out_index, screen_x, screen_y, out_flags, last,
                  input ready);
  modport sink (input valid, out_index, screen_x, screen_y, out_flags, last,
                output ready);
endinterface

interface sbme_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sbme_pkg::CFG_IDX_W-1:0]   index;
  logic [sbme_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/sprite_bounce_motion_engine_top.sv */
// Sprite bounce motion engine: command decode, tick sweep and result queue.
// An in-range set item writes its table entry when accepted; a tick reads one
// sprite per cycle through the single read port while the queue has room, and
// holds off the next request until the last writeback has landed. Results
// leave in sprite order through a two-entry queue that absorbs stalls.
// Reset clears the tables at once through valid bits and loads default limits.
module sprite_bounce_motion_engine_top #(
  parameter int unsigned SPRITE_COUNT  = 64,
  parameter int unsigned FRACTION_BITS = 6
) (
  input  logic        clk,
  input  logic        rst,
  sbme_cmd_if.sink    cmd,
  sbme_res_if.source  result,
  sbme_cfg_if.sink    cfg
);

  localparam int unsigned AW = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(SPRITE_COUNT - 1);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_SWEEP = 2'b10
  } state_t;

  state_t state, state_next;
  logic [AW-1:0] sweep_idx, sweep_idx_next;
  logic [AW-1:0] rd_idx;
  logic          inflight;

  logic [sbme_pkg::POS_W-1:0] right_limit, bottom_limit;

  logic cmd_acc, in_range, issue, pop;
  logic pos_we, mot_we;
  logic [AW-1:0] wr_addr;
  sbme_pkg::pos_entry_t pos_wdata, pos_rdata;
  sbme_pkg::mot_entry_t mot_wdata, mot_rdata;
  sbme_pkg::pos_entry_t pos_upd;
  sbme_pkg::mot_entry_t mot_upd;
  logic [sbme_pkg::POS_W-1:0] shx, shy;
  sbme_pkg::result_t res_new;

  sbme_pkg::result_t q_data [2];
  logic       q_wptr, q_rptr;
  logic [1:0] q_count;

  // Config port
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      right_limit  <= sbme_pkg::RIGHT_LIMIT_RESET;
      bottom_limit <= sbme_pkg::BOTTOM_LIMIT_RESET;
    end else if (cfg.valid) begin
      case (sbme_pkg::cfg_reg_t'(cfg.index))
        sbme_pkg::REG_RIGHT_LIMIT:  right_limit  <= cfg.data;
        sbme_pkg::REG_BOTTOM_LIMIT: bottom_limit <= cfg.data;
        default: ;
      endcase
    end
  end

  // Command side: new requests wait until any sweep is done and the last writeback has landed.
  assign cmd.ready = (state == S_IDLE) && !inflight;
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign in_range  = {1'b0, cmd.sprite_index} < (sbme_pkg::INDEX_W + 1)'(SPRITE_COUNT);

  assign pop = result.valid && result.ready;
  // Issue a read only if its result will find room in the queue.
  assign issue = (state == S_SWEEP) &&
                 ((3'(q_count) + 3'(inflight)) <= (3'd1 + 3'(pop)));

  always_comb begin
    state_next     = state;
    sweep_idx_next = sweep_idx;
    case (state)
      S_IDLE: begin
        if (cmd_acc && (sbme_pkg::kind_t'(cmd.kind) == sbme_pkg::KIND_TICK)) begin
          state_next     = S_SWEEP;
          sweep_idx_next = '0;
        end
      end
      S_SWEEP: begin
        if (issue) begin
          if (sweep_idx == LAST_IDX) begin
            state_next = S_IDLE;
          end else begin
            sweep_idx_next = sweep_idx + 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sweep_idx <= '0;
      inflight  <= 1'b0;
    end else begin
      state     <= state_next;
      sweep_idx <= sweep_idx_next;
      inflight  <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx <= sweep_idx;
    end
  end

  // Update unit on the data read last cycle
  sbme_axis u_axis_x (
    .pos      (pos_rdata.x),
    .vel      (mot_rdata.vx),
    .limit    (right_limit),
    .pos_next (pos_upd.x),
    .vel_next (mot_upd.vx)
  );

  sbme_axis u_axis_y (
    .pos      (pos_rdata.y),
    .vel      (mot_rdata.vy),
    .limit    (bottom_limit),
    .pos_next (pos_upd.y),
    .vel_next (mot_upd.vy)
  );

  assign mot_upd.flags = mot_rdata.flags;

  // Write port: tick writeback or a set request, never both in one cycle.
  always_comb begin
    pos_we    = 1'b0;
    mot_we    = 1'b0;
    wr_addr   = rd_idx;
    pos_wdata = pos_upd;
    mot_wdata = mot_upd;
    if (inflight) begin
      pos_we = 1'b1;
      mot_we = 1'b1;
    end else if (cmd_acc && in_range) begin
      wr_addr         = cmd.sprite_index[AW-1:0];
      pos_wdata.x     = cmd.new_pos_x;
      pos_wdata.y     = cmd.new_pos_y;
      mot_wdata.vx    = cmd.new_vel_x;
      mot_wdata.vy    = cmd.new_vel_y;
      mot_wdata.flags = cmd.new_flags;
      case (sbme_pkg::kind_t'(cmd.kind))
        sbme_pkg::KIND_MOTION:   mot_we = 1'b1;
        sbme_pkg::KIND_POSITION: pos_we = 1'b1;
        default: ;
      endcase
    end
  end

  sbme_store #(
    .DEPTH (SPRITE_COUNT),
    .WIDTH ($bits(sbme_pkg::pos_entry_t)),
    .AW    (AW)
  ) u_pos_store (
    .clk   (clk),
    .rst   (rst),
    .we    (pos_we),
    .waddr (wr_addr),
    .wdata (pos_wdata),
    .re    (issue),
    .raddr (sweep_idx),
    .rdata (pos_rdata)
  );

  sbme_store #(
    .DEPTH (SPRITE_COUNT),
    .WIDTH ($bits(sbme_pkg::mot_entry_t)),
    .AW    (AW)
  ) u_mot_store (
    .clk   (clk),
    .rst   (rst),
    .we    (mot_we),
    .waddr (wr_addr),
    .wdata (mot_wdata),
    .re    (issue),
    .raddr (sweep_idx),
    .rdata (mot_rdata)
  );

  // Result formatting
  assign shx = pos_upd.x >> FRACTION_BITS;
  assign shy = pos_upd.y >> FRACTION_BITS;

  always_comb begin
    res_new.index    = sbme_pkg::INDEX_W'(rd_idx);
    res_new.screen_x = shx[sbme_pkg::SCREEN_W-1:0];
    res_new.screen_y = shy[sbme_pkg::SCREEN_W-1:0];
    res_new.flags    = mot_rdata.flags;
    res_new.last     = (rd_idx == LAST_IDX);
  end

  // Two-entry result queue
  always_ff @(posedge clk) begin
    if (inflight) begin
      q_data[q_wptr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wptr  <= 1'b0;
      q_rptr  <= 1'b0;
      q_count <= '0;
    end else begin
      if (inflight) begin
        q_wptr <= ~q_wptr;
      end
      if (pop) begin
        q_rptr <= ~q_rptr;
      end
      q_count <= q_count + 2'(inflight) - 2'(pop);
    end
  end

  assign result.valid     = (q_count != 2'd0);
  assign result.out_index = q_data[q_rptr].index;
  assign result.screen_x  = q_data[q_rptr].screen_x;
  assign result.screen_y  = q_data[q_rptr].screen_y;
  assign result.out_flags = q_data[q_rptr].flags;
  assign result.last      = q_data[q_rptr].last;

endmodule

/* sv/sbme_store.sv */
// Sprite table memory: one write port, one registered read port, per-entry valid bits.
module sbme_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [WIDTH-1:0] mem_q;
  logic             vld_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q <= mem[raddr];
    end
  end

  // Entries never written read as zero, which stands in for the reset clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (re) begin
        vld_q <= vld[raddr];
      end
    end
  end

  assign rdata = vld_q ? mem_q : '0;

endmodule

/* sv/sbme_axis.sv */
// One axis of motion: add velocity, clamp to [0, limit], bounce the velocity.
module sbme_axis (
  input  logic [sbme_pkg::POS_W-1:0] pos,
  input  logic [sbme_pkg::VEL_W-1:0] vel,
  input  logic [sbme_pkg::POS_W-1:0] limit,
  output logic [sbme_pkg::POS_W-1:0] pos_next,
  output logic [sbme_pkg::VEL_W-1:0] vel_next
);

  localparam int unsigned SW = sbme_pkg::POS_W + 2;

  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] lim_s;

  always_comb begin
    sum   = $signed({2'b00, pos}) +
            $signed({{(SW-sbme_pkg::VEL_W){vel[sbme_pkg::VEL_W-1]}}, vel});
    lim_s = $signed({2'b00, limit});
    if (sum > lim_s) begin
      pos_next = limit;
      vel_next = sbme_pkg::neg_sat(vel);
    end else if (sum < 0) begin
      pos_next = '0;
      vel_next = sbme_pkg::neg_sat(vel);
    end else begin
      pos_next = sum[sbme_pkg::POS_W-1:0];
      vel_next = vel;
    end
  end

endmodule
